// ===== rtl/core/lsfg_pkg.sv =====
// shared constants, register indexes and colour helpers of the led strip frame generator
`timescale 1ns / 1ps

package lsfg_pkg;

  // strip length default
  localparam int NUM_PIXELS_DEF = 32;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_TIME  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_DEPTH = 3'd5;

  // register reset values
  localparam logic [15:0] TICK_STEP_RST   = 16'd20;
  localparam logic [15:0] FADE_TIME_RST   = 16'd1000;
  localparam logic [15:0] BLEND_TIME_RST  = 16'd3000;
  localparam logic [15:0] FLASH_TIME_RST  = 16'd1000;
  localparam logic [15:0] FLASH_GAP_RST   = 16'd2000;
  localparam logic [8:0]  FLASH_DEPTH_RST = 9'd64;

  // item opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  // 1.0 in Q1.16
  localparam logic [16:0] UNIT_Q16 = 17'h10000;

  // colour drawn for a combination code and a random byte, packed r g b
  function automatic logic [23:0] draw_color(input logic [2:0] combo, input logic [7:0] rnd);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = (combo < 3'd2) ? 8'd0 : ((combo < 3'd4) ? 8'd255 : rnd);
    g = (combo == 3'd2 || combo == 3'd4) ? 8'd0 :
        ((combo == 3'd0 || combo == 3'd5) ? 8'd255 : rnd);
    b = (combo == 3'd3 || combo == 3'd5) ? 8'd0 :
        ((combo == 3'd1 || combo == 3'd4) ? 8'd255 : rnd);
    return {r, g, b};
  endfunction

  // one channel byte of a packed colour, 0 red, 1 green, 2 blue
  function automatic logic [7:0] get_byte(input logic [23:0] col, input logic [1:0] k);
    logic [7:0] v;
    unique case (k)
      2'd0:    v = col[23:16];
      2'd1:    v = col[15:8];
      default: v = col[7:0];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/led_strip_frame_generator.sv =====
// led strip frame generator: ramp update, shared divider and multiplier, pixel emission
`timescale 1ns / 1ps

// Usage. An input beat on in_* carries op and the random values; it is taken when
// in_valid_i is high and in_stall_o is low. A toggle beat flips the fade direction
// and gives no pixels. A tick beat advances the fade, both crossfades
// and the flash timer, then sends one beat per pixel on out_*: pixels 0 to N/2-1,
// then N-1 down to N/2, frame_end_o set on the last one.
// Steps of a tick: four divisions on a 33-step restoring divider, then setup
// products on the single multiplier, then per pixel six multiplier steps and
// one output load, which waits while out_stall_i is high. in_stall_o stays
// high for the whole tick.
// A pixel waits in the output register while out_stall_i is high; the sequencer
// holds until it can load the next one, and a new item is taken while the last
// pixel still waits. Configuration writes on cfg_* are always ready; the user
// must make them only while no tick is in progress; the block does not enforce it.
// Reset puts the configuration registers at their default values, colours
// black, fade falling, the flash timer in its waiting phase.

module led_strip_frame_generator #(
  parameter int NUM_PIXELS = lsfg_pkg::NUM_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lsfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsfg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [2:0]                     combo_first_i,
  input  logic [7:0]                     rand_first_i,
  input  logic [2:0]                     combo_second_i,
  input  logic [7:0]                     rand_second_i,
  input  logic [4:0]                     new_flash_pos_i,
  // pixel beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [4:0]                     pixel_index_o,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic                           frame_end_o
);

  localparam int IDX_W = $clog2(NUM_PIXELS);
  localparam int CMP_W = (IDX_W > 5) ? IDX_W : 5;
  localparam int HALF  = NUM_PIXELS / 2;
  localparam int QTR   = NUM_PIXELS / 4;
  localparam int HIGH  = NUM_PIXELS * 3 / 4;
  localparam int DIVQ  = QTR - 1;
  localparam int RECIP = ((1 << 24) + DIVQ - 1) / DIVQ;

  localparam logic [IDX_W-1:0] HALF_C = IDX_W'(HALF);
  localparam logic [IDX_W-1:0] QTR_C  = IDX_W'(QTR);
  localparam logic [IDX_W-1:0] HIGH_C = IDX_W'(HIGH);
  localparam logic [IDX_W-1:0] TOP_C  = IDX_W'(NUM_PIXELS - 1);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(2 * HALF - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DRUN,
    ST_DDONE,
    ST_PREP,
    ST_PIX,
    ST_PUSH
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0] tick_step_q, fade_time_q, blend_time_q, flash_time_q, flash_gap_q;
  logic [8:0]  flash_depth_q;

  // animation state
  logic [15:0] fade_level_q, fade_level_d;
  logic        fade_rising_q;
  logic [23:0] from1_q, to1_q, from2_q, to2_q;
  logic [23:0] from1_d, to1_d, from2_d, to2_d;
  logic [15:0] pos1_q, pos2_q, pos1_d, pos2_d;
  logic [16:0] flash_count_q, flash_count_d;
  logic        flash_waiting_q, flash_waiting_d;
  logic [4:0]  flash_pos_q, flash_pos_d;

  // divider
  logic [1:0]  div_sel_q;
  logic [5:0]  div_cnt_q;
  logic [32:0] dvd_q;
  logic [15:0] rem_q;
  logic [16:0] div_num;
  logic [15:0] div_den;
  logic [16:0] rem_sh, rem_sub;
  logic        div_ge;
  logic [16:0] div_unit;
  logic signed [34:0] tri_full;
  logic signed [26:0] tri_clamp;

  // factors and products
  logic [16:0] ff_q, bf1_q, bf2_q;
  logic signed [26:0] tri_q;
  logic [16:0] m_flash_q, tb_plain_q, tb_flash_q;
  logic [23:0] xf1_q, xf2_q;
  logic signed [44:0] prod_q;
  logic signed [26:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [44:0] mul_p;
  logic        mul_en;

  // sequencer counters
  logic [3:0]  prep_step_q;
  logic [IDX_W-1:0] pix_q;
  logic [2:0]  sub_q;
  logic [7:0]  pix_r_q, pix_g_q;

  // output register
  logic        out_valid_q;
  logic [4:0]  out_idx_q;
  logic [7:0]  out_r_q, out_g_q, out_b_q;
  logic        out_end_q;

  logic in_acc;
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_r_q;
  assign green_o       = out_g_q;
  assign blue_o        = out_b_q;
  assign frame_end_o   = out_end_q;

  // ramp updates of one tick
  logic [16:0] fade_sum, sum1, sum2;
  logic [15:0] start1, start2, flash_thr;
  logic        wrap1, wrap2, flash_wrap;
  logic [16:0] flash_start;

  always_comb begin
    fade_sum     = {1'b0, fade_level_q} + {1'b0, tick_step_q};
    fade_level_d = fade_level_q;
    if (fade_rising_q && fade_level_q < fade_time_q) begin
      fade_level_d = (fade_sum > {1'b0, fade_time_q}) ? fade_time_q : fade_sum[15:0];
    end else if (!fade_rising_q && fade_level_q != 16'd0) begin
      fade_level_d = (tick_step_q >= fade_level_q) ? 16'd0 : fade_level_q - tick_step_q;
    end

    wrap1   = (pos1_q == blend_time_q);
    start1  = wrap1 ? 16'd0 : pos1_q;
    sum1    = {1'b0, start1} + {1'b0, tick_step_q};
    pos1_d  = (sum1 > {1'b0, blend_time_q}) ? blend_time_q : sum1[15:0];
    from1_d = wrap1 ? to1_q : from1_q;
    to1_d   = wrap1 ? lsfg_pkg::draw_color(combo_first_i, rand_first_i) : to1_q;

    wrap2   = (pos2_q == blend_time_q);
    start2  = wrap2 ? 16'd0 : pos2_q;
    sum2    = {1'b0, start2} + {1'b0, tick_step_q};
    pos2_d  = (sum2 > {1'b0, blend_time_q}) ? blend_time_q : sum2[15:0];
    from2_d = wrap2 ? to2_q : from2_q;
    to2_d   = wrap2 ? lsfg_pkg::draw_color(combo_second_i, rand_second_i) : to2_q;

    flash_thr       = flash_waiting_q ? flash_gap_q : flash_time_q;
    flash_wrap      = (flash_count_q >= {1'b0, flash_thr});
    flash_start     = flash_wrap ? 17'd0 : flash_count_q;
    flash_count_d   = flash_start + {1'b0, tick_step_q};
    flash_waiting_d = flash_wrap ? !flash_waiting_q : flash_waiting_q;
    flash_pos_d     = (flash_wrap && flash_waiting_q) ? new_flash_pos_i : flash_pos_q;
  end

  // divider operands and result shaping
  always_comb begin
    unique case (div_sel_q)
      2'd0: begin
        div_num = {1'b0, fade_level_q};
        div_den = fade_time_q;
      end
      2'd1: begin
        div_num = {1'b0, pos1_q};
        div_den = blend_time_q;
      end
      2'd2: begin
        div_num = {1'b0, pos2_q};
        div_den = blend_time_q;
      end
      default: begin
        div_num = flash_count_q;
        div_den = flash_time_q;
      end
    endcase
    rem_sh  = {rem_q, dvd_q[32]};
    div_ge  = (rem_sh >= {1'b0, div_den});
    rem_sub = rem_sh - {1'b0, div_den};
    div_unit = (dvd_q > 33'd65536) ? lsfg_pkg::UNIT_Q16 : dvd_q[16:0];
    // flash triangle, floored far below zero where the flash pixel is dark anyway
    if (dvd_q <= 33'd32768) begin
      tri_full = $signed({2'b00, dvd_q});
    end else begin
      tri_full = 35'sd65536 - $signed({2'b00, dvd_q});
    end
    tri_clamp = (tri_full < -35'sd33554432) ? -27'sd33554432 : 27'(tri_full);
  end

  // setup step decode
  logic [2:0] ch_iss, ch_con;
  logic       iss_hi, con_hi;
  logic [1:0] iss_k, con_k;
  logic [7:0] iss_from, iss_to, con_from, con_val;
  logic signed [44:0] prod_sh16, prod_sh7, m_sum;
  logic signed [18:0] base_s;
  logic [16:0] m_plain, m_flash;

  always_comb begin
    ch_iss   = 3'(prep_step_q - 4'd3);
    ch_con   = 3'(prep_step_q - 4'd4);
    iss_hi   = (ch_iss >= 3'd3);
    con_hi   = (ch_con >= 3'd3);
    iss_k    = iss_hi ? 2'(ch_iss - 3'd3) : ch_iss[1:0];
    con_k    = con_hi ? 2'(ch_con - 3'd3) : ch_con[1:0];
    iss_from = lsfg_pkg::get_byte(iss_hi ? from2_q : from1_q, iss_k);
    iss_to   = lsfg_pkg::get_byte(iss_hi ? to2_q : to1_q, iss_k);
    con_from = lsfg_pkg::get_byte(con_hi ? from2_q : from1_q, con_k);
    prod_sh16 = prod_q >>> 16;
    con_val  = con_from + prod_sh16[7:0];

    // base brightness and the flash boost at the flash pixel
    base_s   = 19'sd65536 - $signed({2'b00, flash_depth_q, 8'd0});
    m_plain  = (base_s < 19'sd0) ? 17'd0 : base_s[16:0];
    prod_sh7 = flash_waiting_q ? 45'sd0 : (prod_q >>> 7);
    m_sum    = prod_sh7 + 45'(base_s);
    if (m_sum < 45'sd0) begin
      m_flash = 17'd0;
    end else if (m_sum > 45'sd65536) begin
      m_flash = lsfg_pkg::UNIT_Q16;
    end else begin
      m_flash = m_sum[16:0];
    end
  end

  // pixel decode
  logic             pix_half, pix_outer, pix_hit;
  logic [IDX_W-1:0] pix_j, pix_idx, pix_jq;
  logic [1:0]       pix_k;
  logic [7:0]       pix_c;
  logic [12:0]      pix_coef;
  logic [16:0]      pix_tb;
  logic [20:0]      ch_full;
  logic [7:0]       ch_sat;

  always_comb begin
    pix_half  = (pix_q >= HALF_C);
    pix_j     = pix_half ? pix_q - HALF_C : pix_q;
    pix_idx   = pix_half ? TOP_C - pix_j : pix_j;
    pix_jq    = pix_j - QTR_C;
    pix_outer = (pix_idx < QTR_C) || (pix_idx >= HIGH_C);
    pix_hit   = (CMP_W'(pix_idx) == CMP_W'(flash_pos_q));
    pix_k     = sub_q[2:1];
    pix_c     = lsfg_pkg::get_byte(pix_half ? xf2_q : xf1_q, pix_k);
    if (pix_outer) begin
      // scaled up by the shared divisor so the common divide step gives c * tb
      pix_coef = 13'(14'(pix_c) * 14'(DIVQ));
    end else begin
      // middle pixels lean toward white with their distance from the quarter mark
      pix_coef = 13'(14'(pix_c) * 14'(DIVQ) + 14'(8'd255 - pix_c) * 14'(pix_jq));
    end
    pix_tb  = pix_hit ? tb_flash_q : tb_plain_q;
    ch_full = prod_q[44:24];
    ch_sat  = (ch_full > 21'd255) ? 8'd255 : ch_full[7:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    if (state_q == ST_PREP) begin
      mul_en = (prep_step_q <= 4'd8);
      if (prep_step_q == 4'd0) begin
        mul_a = tri_q;
        mul_b = $signed({9'd0, flash_depth_q});
      end else if (prep_step_q == 4'd1) begin
        mul_a = $signed({10'd0, ff_q});
        mul_b = $signed({1'b0, m_plain});
      end else if (prep_step_q == 4'd2) begin
        mul_a = $signed({10'd0, ff_q});
        mul_b = $signed({1'b0, m_flash_q});
      end else begin
        mul_a = $signed({10'd0, iss_hi ? bf2_q : bf1_q});
        mul_b = 18'($signed({1'b0, iss_to}) - $signed({1'b0, iss_from}));
      end
    end else if (state_q == ST_PIX) begin
      mul_en = 1'b1;
      if (!sub_q[0]) begin
        mul_a = $signed({10'd0, pix_tb});
        mul_b = $signed({5'd0, pix_coef});
      end else begin
        // divide by the quarter length less one through its reciprocal
        mul_a = 27'(RECIP);
        mul_b = $signed({5'd0, prod_q[28:16]});
      end
    end
    mul_p = 45'(mul_a) * 45'(mul_b);
  end

  logic push_ok;
  assign push_ok = !out_valid_q || !out_stall_i;

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      tick_step_q     <= lsfg_pkg::TICK_STEP_RST;
      fade_time_q     <= lsfg_pkg::FADE_TIME_RST;
      blend_time_q    <= lsfg_pkg::BLEND_TIME_RST;
      flash_time_q    <= lsfg_pkg::FLASH_TIME_RST;
      flash_gap_q     <= lsfg_pkg::FLASH_GAP_RST;
      flash_depth_q   <= lsfg_pkg::FLASH_DEPTH_RST;
      fade_level_q    <= '0;
      fade_rising_q   <= 1'b0;
      from1_q         <= '0;
      to1_q           <= '0;
      from2_q         <= '0;
      to2_q           <= '0;
      pos1_q          <= '0;
      pos2_q          <= '0;
      flash_count_q   <= '0;
      flash_waiting_q <= 1'b1;
      flash_pos_q     <= '0;
      div_sel_q       <= '0;
      div_cnt_q       <= '0;
      prep_step_q     <= '0;
      pix_q           <= '0;
      sub_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lsfg_pkg::REG_TICK_STEP:   tick_step_q   <= cfg_data_i;
          lsfg_pkg::REG_FADE_TIME:   fade_time_q   <= cfg_data_i;
          lsfg_pkg::REG_BLEND_TIME:  blend_time_q  <= cfg_data_i;
          lsfg_pkg::REG_FLASH_TIME:  flash_time_q  <= cfg_data_i;
          lsfg_pkg::REG_FLASH_GAP:   flash_gap_q   <= cfg_data_i;
          lsfg_pkg::REG_FLASH_DEPTH: flash_depth_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end

      // output beat taken, unless a new pixel is loaded in the same cycle
      if (out_valid_q && !out_stall_i && !(state_q == ST_PUSH && push_ok)) begin
        out_valid_q <= 1'b0;
      end

      if (mul_en) begin
        prod_q <= mul_p;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_i == lsfg_pkg::OP_TOGGLE) begin
              fade_rising_q <= !fade_rising_q;
            end else begin
              fade_level_q    <= fade_level_d;
              from1_q         <= from1_d;
              to1_q           <= to1_d;
              pos1_q          <= pos1_d;
              from2_q         <= from2_d;
              to2_q           <= to2_d;
              pos2_q          <= pos2_d;
              flash_count_q   <= flash_count_d;
              flash_waiting_q <= flash_waiting_d;
              flash_pos_q     <= flash_pos_d;
              div_sel_q       <= 2'd0;
              state_q         <= ST_DLOAD;
            end
          end
        end

        ST_DLOAD: begin
          rem_q <= '0;
          if (div_den == 16'd0) begin
            // zero length reads as a full factor
            dvd_q   <= 33'(lsfg_pkg::UNIT_Q16);
            state_q <= ST_DDONE;
          end else begin
            dvd_q     <= {div_num, 16'd0};
            div_cnt_q <= 6'd33;
            state_q   <= ST_DRUN;
          end
        end

        ST_DRUN: begin
          // one quotient bit per cycle
          rem_q     <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
          dvd_q     <= {dvd_q[31:0], div_ge};
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == 6'd1) begin
            state_q <= ST_DDONE;
          end
        end

        ST_DDONE: begin
          unique case (div_sel_q)
            2'd0:    ff_q  <= div_unit;
            2'd1:    bf1_q <= div_unit;
            2'd2:    bf2_q <= div_unit;
            default: tri_q <= tri_clamp;
          endcase
          if (div_sel_q == 2'd3) begin
            prep_step_q <= '0;
            state_q     <= ST_PREP;
          end else begin
            div_sel_q <= div_sel_q + 2'd1;
            state_q   <= ST_DLOAD;
          end
        end

        ST_PREP: begin
          // consume the product issued one step earlier
          if (prep_step_q == 4'd1) begin
            m_flash_q <= m_flash;
          end else if (prep_step_q == 4'd2) begin
            tb_plain_q <= prod_q[32:16];
          end else if (prep_step_q == 4'd3) begin
            tb_flash_q <= prod_q[32:16];
          end else if (prep_step_q >= 4'd4) begin
            unique case (ch_con)
              3'd0:    xf1_q[23:16] <= con_val;
              3'd1:    xf1_q[15:8]  <= con_val;
              3'd2:    xf1_q[7:0]   <= con_val;
              3'd3:    xf2_q[23:16] <= con_val;
              3'd4:    xf2_q[15:8]  <= con_val;
              default: xf2_q[7:0]   <= con_val;
            endcase
          end
          if (prep_step_q == 4'd9) begin
            pix_q   <= '0;
            sub_q   <= '0;
            state_q <= ST_PIX;
          end else begin
            prep_step_q <= prep_step_q + 4'd1;
          end
        end

        ST_PIX: begin
          if (sub_q == 3'd2) begin
            pix_r_q <= ch_sat;
          end else if (sub_q == 3'd4) begin
            pix_g_q <= ch_sat;
          end
          if (sub_q == 3'd5) begin
            state_q <= ST_PUSH;
          end else begin
            sub_q <= sub_q + 3'd1;
          end
        end

        ST_PUSH: begin
          if (push_ok) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= 5'(CMP_W'(pix_idx));
            out_r_q     <= pix_r_q;
            out_g_q     <= pix_g_q;
            out_b_q     <= ch_sat;
            out_end_q   <= (pix_q == LAST_C);
            sub_q       <= '0;
            if (pix_q == LAST_C) begin
              state_q <= ST_IDLE;
            end else begin
              pix_q   <= pix_q + 1'b1;
              state_q <= ST_PIX;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the led strip frame generator with its own frame predictor
`timescale 1ns / 1ps

module tb;

  localparam int NPIX  = 32;
  localparam int QUART = NPIX / 4;

  typedef struct packed {
    logic       op;
    logic [2:0] cf;
    logic [7:0] rf;
    logic [2:0] cs;
    logic [7:0] rs;
    logic [4:0] pos;
  } beat_t;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } pixel_t;

  // directed row: the beat and whether its frame is plainly black
  typedef struct packed {
    beat_t beat;
    logic  black;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [lsfg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [lsfg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = lsfg_pkg::OP_TICK;
  logic [2:0] combo_first_i = '0;
  logic [7:0] rand_first_i = '0;
  logic [2:0] combo_second_i = '0;
  logic [7:0] rand_second_i = '0;
  logic [4:0] new_flash_pos_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [4:0] pixel_index_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic frame_end_o;

  led_strip_frame_generator #(.NUM_PIXELS(NPIX)) i_dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor copy of registers and ramps
  longint step_r, fade_r, blend_r, ftime_r, fgap_r, depth_r;
  longint fade_lvl, blend_a, blend_b, fcount, fpos;
  logic   rising, waiting;
  logic [23:0] from_a, to_a, from_b, to_b;

  pixel_t pending_pixels[$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint fdiv(input longint x, input longint d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic longint ratio_q16(input longint num, input longint den);
    longint f;
    if (den == 0) return 65536;
    f = (num << 16) / den;
    return (f > 65536) ? 65536 : f;
  endfunction

  function automatic logic [7:0] clamp8(input longint num, input longint den);
    longint v;
    v = fdiv(num, den);
    if (v < 0) return 8'd0;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // primary colour pick: each channel off, full or random
  function automatic logic [23:0] pick_color(input logic [2:0] combo, input logic [7:0] rnd);
    logic [7:0] r, g, b;
    case (combo)
      3'd0:    begin r = 8'd0;   g = 8'd255; b = rnd;    end
      3'd1:    begin r = 8'd0;   g = rnd;    b = 8'd255; end
      3'd2:    begin r = 8'd255; g = 8'd0;   b = rnd;    end
      3'd3:    begin r = 8'd255; g = rnd;    b = 8'd0;   end
      3'd4:    begin r = rnd;    g = 8'd0;   b = 8'd255; end
      3'd5:    begin r = rnd;    g = 8'd255; b = 8'd0;   end
      default: begin r = rnd;    g = rnd;    b = rnd;    end
    endcase
    return {r, g, b};
  endfunction

  // one crossfade step, returns the mixed colour
  task automatic crossfade(inout logic [23:0] from, inout logic [23:0] to, inout longint pos,
                           input logic [2:0] combo, input logic [7:0] rnd,
                           output logic [23:0] mix);
    longint bf, a, b, v;
    if (pos == blend_r) begin
      pos = 0;
      from = to;
      to = pick_color(combo, rnd);
    end
    v = pos + step_r;
    pos = (v > blend_r) ? blend_r : v;
    bf = ratio_q16(pos, blend_r);
    for (int k = 0; k < 3; k++) begin
      a = from[8*k +: 8];
      b = to[8*k +: 8];
      v = (a * (65536 - bf) + b * bf) >> 16;
      mix[8*k +: 8] = v[7:0];
    end
  endtask

  task automatic reset_model();
    step_r = lsfg_pkg::TICK_STEP_RST; fade_r = lsfg_pkg::FADE_TIME_RST;
    blend_r = lsfg_pkg::BLEND_TIME_RST; ftime_r = lsfg_pkg::FLASH_TIME_RST;
    fgap_r = lsfg_pkg::FLASH_GAP_RST; depth_r = lsfg_pkg::FLASH_DEPTH_RST;
    fade_lvl = 0; rising = 1'b0; waiting = 1'b1; fcount = 0; fpos = 0;
    from_a = '0; to_a = '0; from_b = '0; to_b = '0; blend_a = 0; blend_b = 0;
  endtask

  // predict the frame of one accepted beat
  task automatic predict_frame(input beat_t bt, input logic black);
    logic [23:0] c1, c2, col;
    longint ff, fb, base, thr, pf, tri_v, m, tb, c, idx, v;
    pixel_t px;
    if (bt.op == lsfg_pkg::OP_TOGGLE) begin
      rising = ~rising;
      return;
    end
    if (rising && fade_lvl < fade_r) begin
      v = fade_lvl + step_r;
      fade_lvl = (v > fade_r) ? fade_r : v;
    end else if (!rising && fade_lvl > 0) begin
      fade_lvl = (step_r >= fade_lvl) ? 0 : fade_lvl - step_r;
    end
    crossfade(from_a, to_a, blend_a, bt.cf, bt.rf, c1);
    crossfade(from_b, to_b, blend_b, bt.cs, bt.rs, c2);
    thr = waiting ? fgap_r : ftime_r;
    if (fcount >= thr) begin
      fcount = 0;
      waiting = ~waiting;
      if (!waiting) fpos = bt.pos;
    end
    fcount = (fcount + step_r) & 64'h1FFFF;
    ff = ratio_q16(fade_lvl, fade_r);
    fb = 0;
    if (!waiting) begin
      pf = (ftime_r == 0) ? 65536 : (fcount << 16) / ftime_r;
      tri_v = (pf <= 32768) ? pf : 65536 - pf;
      fb = fdiv(tri_v * depth_r, 128);
    end
    base = 65536 - depth_r * 256;
    for (int h = 0; h < 2; h++) begin
      col = (h == 0) ? c1 : c2;
      for (int j = 0; j < NPIX / 2; j++) begin
        idx = (h == 0) ? j : NPIX - 1 - j;
        m = base + ((idx == fpos) ? fb : 0);
        tb = fdiv(ff * m, 65536);
        px.idx = idx[4:0];
        for (int k = 0; k < 3; k++) begin
          c = col[16 - 8*k +: 8];
          if (idx < QUART || idx >= 3 * QUART)
            v = clamp8(c * tb, 65536);
          else
            v = clamp8((c * (QUART - 1) + (255 - c) * (j - QUART)) * tb,
                       (QUART - 1) * 65536);
          if (black) v = 0;
          case (k)
            0: px.r = v[7:0];
            1: px.g = v[7:0];
            default: px.b = v[7:0];
          endcase
        end
        px.fe = (h == 1 && j == NPIX / 2 - 1);
        pending_pixels.push_back(px);
      end
    end
  endtask

  // offer one beat, wait for acceptance
  task automatic offer(input beat_t bt, input logic black);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= bt.op;
    combo_first_i <= bt.cf;
    rand_first_i <= bt.rf;
    combo_second_i <= bt.cs;
    rand_second_i <= bt.rs;
    new_flash_pos_i <= bt.pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame(bt, black);
    @(negedge clk_i);
  endtask

  // write one register on a drained block, valid stays up for the caller to drop
  task automatic write_reg(input logic [lsfg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      lsfg_pkg::REG_TICK_STEP:  step_r = data;
      lsfg_pkg::REG_FADE_TIME:  fade_r = data;
      lsfg_pkg::REG_BLEND_TIME: blend_r = data;
      lsfg_pkg::REG_FLASH_TIME: ftime_r = data;
      lsfg_pkg::REG_FLASH_GAP:  fgap_r = data;
      default:                  depth_r = data[8:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic beat_t rand_beat();
    beat_t bt;
    bt.op = ($urandom_range(99) < 15) ? lsfg_pkg::OP_TOGGLE : lsfg_pkg::OP_TICK;
    bt.cf = $urandom_range(7);
    bt.rf = $urandom_range(255);
    bt.cs = $urandom_range(7);
    bt.rs = $urandom_range(255);
    bt.pos = $urandom_range(31);
    return bt;
  endfunction

  // receiver side stall pattern, with a long hold on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle);
    end
  end

  // pixel beat checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected pixel", pixel_index_o, -1);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_index_o !== want.idx) report("pixel_index", pixel_index_o, want.idx);
        if (red_o !== want.r) report("red", red_o, want.r);
        if (green_o !== want.g) report("green", green_o, want.g);
        if (blue_o !== want.b) report("blue", blue_o, want.b);
        if (frame_end_o !== want.fe) report("frame_end", frame_end_o, want.fe);
      end
    end
  end

  // register settings of the random phases
  logic [15:0] setting [5][6] = '{
    '{16'd1000,  16'd5000,  16'd3000,  16'd2000,  16'd500,   16'd256},
    '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0},
    '{16'd1,     16'd1,     16'd1,     16'd1,     16'd0,     16'd300},
    '{16'd300,   16'd0,     16'd0,     16'd0,     16'd0,     16'd511},
    '{16'd700,   16'd4000,  16'd2500,  16'd3000,  16'd1000,  16'd128}
  };

  // directed rows: black while the fade is still at zero and falling
  row_t directed [20] = '{
    '{'{lsfg_pkg::OP_TICK,   3'd0, 8'd0,   3'd7, 8'd255, 5'd0},  1'b1},
    '{'{lsfg_pkg::OP_TICK,   3'd7, 8'd255, 3'd0, 8'd0,   5'd31}, 1'b1},
    '{'{lsfg_pkg::OP_TOGGLE, 3'd0, 8'd0,   3'd0, 8'd0,   5'd0},  1'b0},
    '{'{lsfg_pkg::OP_TOGGLE, 3'd7, 8'd255, 3'd7, 8'd255, 5'd31}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd1, 8'd255, 3'd2, 8'd0,   5'd0},  1'b1},
    '{'{lsfg_pkg::OP_TOGGLE, 3'd0, 8'd0,   3'd0, 8'd0,   5'd0},  1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd0, 8'd255, 3'd1, 8'd0,   5'd31}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd2, 8'd128, 3'd3, 8'd1,   5'd7},  1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd4, 8'd0,   3'd5, 8'd255, 5'd8},  1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd6, 8'd77,  3'd7, 8'd200, 5'd15}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd3, 8'd255, 3'd6, 8'd0,   5'd16}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd5, 8'd9,   3'd4, 8'd99,  5'd23}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd7, 8'd0,   3'd2, 8'd255, 5'd24}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd1, 8'd170, 3'd0, 8'd85,  5'd31}, 1'b0},
    '{'{lsfg_pkg::OP_TOGGLE, 3'd0, 8'd0,   3'd0, 8'd0,   5'd0},  1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd0, 8'd1,   3'd1, 8'd2,   5'd3},  1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd2, 8'd3,   3'd3, 8'd4,   5'd5},  1'b0},
    '{'{lsfg_pkg::OP_TOGGLE, 3'd0, 8'd0,   3'd0, 8'd0,   5'd0},  1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd4, 8'd5,   3'd5, 8'd6,   5'd12}, 1'b0},
    '{'{lsfg_pkg::OP_TICK,   3'd6, 8'd7,   3'd7, 8'd8,   5'd20}, 1'b0}
  };

  // main sequence
  initial begin
    reset_model();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    snd_idle = 37;
    rcv_idle = 67;
    foreach (directed[i]) offer(directed[i].beat, directed[i].black);
    for (int p = 0; p < 5; p++) begin
      settle();
      for (int r = 0; r < 6; r++) write_reg(r[lsfg_pkg::CFG_IDX_W-1:0], setting[p][r]);
      cfg_valid_i <= 1'b0;
      if (p == 2) begin
        snd_idle = 67;
        rcv_idle = 37;
      end else if (p == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      // long receiver hold while beats keep coming
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < 50; n++) offer(rand_beat(), 1'b0);
    end
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
